FILE: rtl/rect_fill_point_read_grid_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle fill / point read grid
// Shared property forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef RECT_FILL_POINT_READ_GRID_MACROS_SVH
`define RECT_FILL_POINT_READ_GRID_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RFG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rfg assertion failed");

// next-cycle implication, disabled while reset is asserted
`define RFG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rfg assertion failed");

`endif

FILE: rtl/rfg_pkg.sv
// ---------------------------------------------------------------------------
// rfg_pkg
// Types and constants shared by the grid front end, command queue and back end.
// ---------------------------------------------------------------------------
package rfg_pkg;

	localparam int COORD_W     = 7;
	localparam int VALUE_W     = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	// req_type codes
	localparam logic REQ_FILL = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef enum logic [1:0] {
		CMD_FILL,   // clipped, non-empty rectangle
		CMD_READ,   // in-range cell read
		CMD_ZERO    // read outside the grid, answers zero
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                   kind;
		logic [COORD_W-1:0]          top;
		logic [COORD_W-1:0]          left;
		logic [COORD_W-1:0]          bottom;
		logic [COORD_W-1:0]          right;
		logic signed [VALUE_W-1:0]   value;
	} cmd_t;

	typedef enum logic {
		BK_IDLE,
		BK_FILL
	} back_state_t;

endpackage

FILE: rtl/rect_fill_point_read_grid.sv
// ---------------------------------------------------------------------------
// rect_fill_point_read_grid
// Grid of signed 32-bit cells with rectangle fill and single-cell read.
// ---------------------------------------------------------------------------
// A read request gives one result word; a fill gives none and an empty or
// fully clipped fill is dropped at the input. Requests are done in order.
// The front end takes one word per cycle while the four-entry command queue
// has room. In the back end an in-grid read uses the single read port when
// the output buffer has room; its word goes through the read register and
// then the output buffer. A fill loads the walker, then writes each clipped
// cell in turn on the single write port and takes no new command until done.
// Cells are not cleared after reset: read only cells that a fill has
// written. Reads outside the grid return zero.
// ---------------------------------------------------------------------------
module rect_fill_point_read_grid import rfg_pkg::*; #(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [COORD_W-1:0]        row_top,
	input  logic [COORD_W-1:0]        col_left,
	input  logic [COORD_W-1:0]        row_bottom,
	input  logic [COORD_W-1:0]        col_right,
	input  logic signed [VALUE_W-1:0] fill_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] cell_value
);

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_valid;
	cmd_t q_cmd;
	cmd_t q_head;

	rfg_front #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.row_top    (row_top),
		.col_left   (col_left),
		.row_bottom (row_bottom),
		.col_right  (col_right),
		.fill_value (fill_value),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_cmd      (q_cmd)
	);

	rfg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head      (q_head)
	);

	rfg_back #(
		.GRID_ROWS (GRID_ROWS),
		.GRID_COLS (GRID_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_value (cell_value)
	);

endmodule

FILE: rtl/rfg_front.sv
// ---------------------------------------------------------------------------
// rfg_front
// Accepts request words, clips fill rectangles to the grid, drops empty
// fills and flags out-of-grid reads before they enter the command queue.
// ---------------------------------------------------------------------------
module rfg_front import rfg_pkg::*; #(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128
) (
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      req_type,
	input  logic [COORD_W-1:0]        row_top,
	input  logic [COORD_W-1:0]        col_left,
	input  logic [COORD_W-1:0]        row_bottom,
	input  logic [COORD_W-1:0]        col_right,
	input  logic signed [VALUE_W-1:0] fill_value,
	input  logic                      q_full,
	output logic                      q_push,
	output cmd_t                      q_cmd
);

	localparam logic [31:0] LAST_ROW = 32'(GRID_ROWS - 1);
	localparam logic [31:0] LAST_COL = 32'(GRID_COLS - 1);

	logic               is_read;
	logic               in_grid;
	logic               empty_rect;
	logic [COORD_W-1:0] bot_clip;
	logic [COORD_W-1:0] right_clip;

	always_comb begin
		is_read    = (req_type == REQ_READ);
		in_grid    = (32'(row_top) <= LAST_ROW) && (32'(col_left) <= LAST_COL);
		bot_clip   = (32'(row_bottom) > LAST_ROW) ? LAST_ROW[COORD_W-1:0] : row_bottom;
		right_clip = (32'(col_right) > LAST_COL) ? LAST_COL[COORD_W-1:0] : col_right;
		empty_rect = (row_top > bot_clip) || (col_left > right_clip);

		q_cmd.top    = row_top;
		q_cmd.left   = col_left;
		q_cmd.bottom = bot_clip;
		q_cmd.right  = right_clip;
		q_cmd.value  = fill_value;
		if (is_read) begin
			q_cmd.kind = in_grid ? CMD_READ : CMD_ZERO;
		end else begin
			q_cmd.kind = CMD_FILL;
		end
	end

	assign in_stall = q_full;
	// empty fills are taken and dropped here
	assign q_push   = in_valid && !q_full && (is_read || !empty_rect);

endmodule

FILE: rtl/rfg_queue.sv
// ---------------------------------------------------------------------------
// rfg_queue
// Short command FIFO between the front end and the back end.
// ---------------------------------------------------------------------------
module rfg_queue import rfg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	cmd_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/rfg_back.sv
// ---------------------------------------------------------------------------
// rfg_back
// Executes queued commands against the cell memory: fills walk the
// rectangle one cell per cycle, reads go through a registered memory read
// into a two-word output buffer.
// ---------------------------------------------------------------------------
module rfg_back import rfg_pkg::*; #(
	parameter int GRID_ROWS = 128,
	parameter int GRID_COLS = 128
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  cmd_t                      q_head,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] cell_value
);

	localparam int DEPTH  = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [VALUE_W-1:0] mem [DEPTH];

	back_state_t        state_q;
	back_state_t        state_nxt;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] left_q;
	logic [COORD_W-1:0] bot_q;
	logic [COORD_W-1:0] right_q;
	logic [VALUE_W-1:0] val_q;

	logic               last_col;
	logic               last_row;
	logic               start_fill;
	logic               rd_en;
	logic               mem_wr;
	logic               mem_rd;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;

	logic               rd_valid_s1;
	logic               rd_zero_s1;
	logic [VALUE_W-1:0] rd_data_s1;
	logic [VALUE_W-1:0] land_word;

	// two-word output buffer, entry 0 drives the port
	logic               v0_q;
	logic               v1_q;
	logic [VALUE_W-1:0] e0_q;
	logic [VALUE_W-1:0] e1_q;
	logic               out_pop;
	logic [1:0]         occ;
	logic               room;

	assign last_col = (col_q == right_q);
	assign last_row = (row_q == bot_q);
	assign out_pop  = v0_q && !out_stall;
	// words buffered plus the read in flight; after this edge's pop at most one
	// may remain so a new read always has a place to land
	assign occ      = {1'b0, v0_q} + {1'b0, v1_q} + {1'b0, rd_valid_s1};
	assign room     = (occ - {1'b0, out_pop}) < 2'd2;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (start_fill) begin
					state_nxt = BK_FILL;
				end
			end
			BK_FILL: begin
				if (last_col && last_row) begin
					state_nxt = BK_IDLE;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		q_pop      = 1'b0;
		rd_en      = 1'b0;
		start_fill = 1'b0;
		mem_wr     = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					unique case (q_head.kind)
						CMD_FILL: begin
							q_pop      = 1'b1;
							start_fill = 1'b1;
						end
						CMD_READ, CMD_ZERO: begin
							q_pop = room;
							rd_en = room;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			BK_FILL: begin
				mem_wr = 1'b1;
			end
		endcase
	end

	assign mem_rd  = rd_en && (q_head.kind == CMD_READ);
	assign wr_addr = ADDR_W'(32'(row_q) * 32'(GRID_COLS) + 32'(col_q));
	assign rd_addr = ADDR_W'(32'(q_head.top) * 32'(GRID_COLS) + 32'(q_head.left));

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[wr_addr] <= val_q;
		end
		if (mem_rd) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// rectangle walker
	always_ff @(posedge clk) begin
		if (start_fill) begin
			row_q   <= q_head.top;
			col_q   <= q_head.left;
			left_q  <= q_head.left;
			bot_q   <= q_head.bottom;
			right_q <= q_head.right;
			val_q   <= q_head.value;
		end else if (state_q == BK_FILL) begin
			if (last_col) begin
				col_q <= left_q;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			rd_valid_s1 <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_zero_s1 <= (q_head.kind == CMD_ZERO);
		end
	end

	assign land_word = rd_zero_s1 ? '0 : rd_data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_q <= 1'b0;
			v1_q <= 1'b0;
		end else begin
			priority if (out_pop && rd_valid_s1) begin
				v0_q <= 1'b1;
			end else if (out_pop) begin
				v0_q <= v1_q;
				v1_q <= 1'b0;
			end else if (rd_valid_s1) begin
				if (v0_q) begin
					v1_q <= 1'b1;
				end else begin
					v0_q <= 1'b1;
				end
			end else begin
				v0_q <= v0_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (out_pop && rd_valid_s1) begin
			if (v1_q) begin
				e0_q <= e1_q;
				e1_q <= land_word;
			end else begin
				e0_q <= land_word;
			end
		end else if (out_pop) begin
			e0_q <= e1_q;
		end else if (rd_valid_s1) begin
			if (v0_q) begin
				e1_q <= land_word;
			end else begin
				e0_q <= land_word;
			end
		end else begin
			e0_q <= e0_q;
		end
	end

	assign out_valid  = v0_q;
	assign cell_value = signed'(e0_q);

endmodule

FILE: rtl/rfg_checker.sv
// ---------------------------------------------------------------------------
// rfg_checker
// Port-level checks for the grid, bound to the top level.
// ---------------------------------------------------------------------------
`include "rect_fill_point_read_grid_macros.svh"

module rfg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] cell_value
);

	// a held result word stays put
	`RFG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(cell_value))

	// first cycle out of reset: queue empty, no result pending
	`RFG_ASSERT_NOW(a_reset_idle, clk, arst_n, !$past(arst_n), !in_stall && !out_valid)

	// queue only fills up on an accepted word
	`RFG_ASSERT_NOW(a_stall_cause, clk, arst_n, $rose(in_stall), $past(in_valid && !in_stall))

endmodule

bind rect_fill_point_read_grid rfg_checker u_rfg_checker (.*);

FILE: test/rect_fill_point_read_grid_test.sv
// ---------------------------------------------------------------------------
// rect_fill_point_read_grid_test
// Self-checking bench for the rectangle fill / point read grid.
// ---------------------------------------------------------------------------
// A full-grid fill runs first, so every later read hits a written cell. A
// short table covers corners, edge rows and columns, value extremes and empty
// rectangles. Random fills and reads follow in four idle/stall phases. A
// local grid copy predicts each read word that the table does not fix, and
// the expected words are matched in order against the output channel.
// ---------------------------------------------------------------------------
module rect_fill_point_read_grid_test;
	import rfg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int GRID_ROWS = 128;
	localparam int GRID_COLS = 128;
	localparam int PHASE_ITEMS = 132;
	localparam int DRAIN_CYCLES = 40;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct packed {
		logic   kind;
		coord_t top;
		coord_t left;
		coord_t bottom;
		coord_t right;
		value_t value;
		logic   fixed;
		value_t fixed_word;
	} request_row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	logic   req_type = REQ_FILL;
	coord_t row_top = '0;
	coord_t col_left = '0;
	coord_t row_bottom = '0;
	coord_t col_right = '0;
	value_t fill_value = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	value_t cell_value;

	value_t grid_model [GRID_ROWS*GRID_COLS];
	value_t expected_cells [$];
	request_row_t request_table [$];
	int mismatch_count = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct = 0;

	// most recent fill, so reads can target freshly written cells
	coord_t fresh_top = '0, fresh_left = '0, fresh_bottom = '0, fresh_right = '0;

	rect_fill_point_read_grid #(
		.GRID_ROWS(GRID_ROWS),
		.GRID_COLS(GRID_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.row_top(row_top),
		.col_left(col_left),
		.row_bottom(row_bottom),
		.col_right(col_right),
		.fill_value(fill_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cell_value(cell_value)
	);

	always #2 clk = ~clk;

	initial begin
		#10ms;
		$display("rect_fill_point_read_grid verification failed");
		$finish;
	end

	// grid update for one request; a read yields the word it returns
	task automatic update_grid(input logic kind, input coord_t top, input coord_t left,
			input coord_t bottom, input coord_t right, input value_t value,
			output bit has_word, output value_t word);
		int unsigned last_row;
		int unsigned last_col;
		has_word = 1'b0;
		word = '0;
		if (kind == REQ_FILL) begin
			last_row = (bottom > GRID_ROWS - 1) ? GRID_ROWS - 1 : 32'(bottom);
			last_col = (right > GRID_COLS - 1) ? GRID_COLS - 1 : 32'(right);
			if (top > last_row || left > last_col)
				return;
			for (int unsigned r = 32'(top); r <= last_row; r++)
				for (int unsigned c = 32'(left); c <= last_col; c++)
					grid_model[r*GRID_COLS + c] = value;
		end else begin
			has_word = 1'b1;
			if (top < GRID_ROWS && left < GRID_COLS)
				word = grid_model[top*GRID_COLS + left];
		end
	endtask

	task automatic send_request(input request_row_t rq);
		bit has_word;
		value_t word;
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		req_type <= rq.kind;
		row_top <= rq.top;
		col_left <= rq.left;
		row_bottom <= rq.bottom;
		col_right <= rq.right;
		fill_value <= rq.value;
		do @(posedge clk); while (in_stall);
		update_grid(rq.kind, rq.top, rq.left, rq.bottom, rq.right, rq.value, has_word, word);
		if (has_word)
			expected_cells.push_back(rq.fixed ? rq.fixed_word : word);
		if (rq.kind == REQ_FILL && rq.top <= rq.bottom && rq.left <= rq.right) begin
			fresh_top = rq.top;
			fresh_left = rq.left;
			fresh_bottom = rq.bottom;
			fresh_right = rq.right;
		end
	endtask

	task automatic add_row(input logic kind, input int top, input int left, input int bottom,
			input int right, input value_t value, input logic fixed, input value_t fixed_word);
		request_row_t rq;
		rq.kind = kind;
		rq.top = coord_t'(top);
		rq.left = coord_t'(left);
		rq.bottom = coord_t'(bottom);
		rq.right = coord_t'(right);
		rq.value = value;
		rq.fixed = fixed;
		rq.fixed_word = fixed_word;
		request_table.push_back(rq);
	endtask

	function automatic request_row_t random_request(input int idx);
		request_row_t rq;
		int h;
		int w;
		int sel;
		coord_t tmp;
		rq.kind = 1'($urandom_range(1));
		rq.top = coord_t'($urandom_range(127));
		rq.left = coord_t'($urandom_range(127));
		rq.bottom = coord_t'($urandom_range(127));
		rq.right = coord_t'($urandom_range(127));
		rq.value = $urandom;
		rq.fixed = 1'b0;
		rq.fixed_word = '0;
		sel = $urandom_range(99);
		if (rq.kind == REQ_READ) begin
			if (sel < 50) begin
				rq.top = coord_t'($urandom_range(fresh_bottom, fresh_top));
				rq.left = coord_t'($urandom_range(fresh_right, fresh_left));
			end
			return rq;
		end
		case ($urandom_range(9))
			0: rq.value = 32'sh7FFF_FFFF;
			1: rq.value = 32'sh8000_0000;
			2: rq.value = -32'sd1;
			default: ;
		endcase
		if (idx % 60 == 59) begin
			// occasional big rectangle anywhere in the grid
			if (rq.top > rq.bottom) begin
				tmp = rq.top; rq.top = rq.bottom; rq.bottom = tmp;
			end
			if (rq.left > rq.right) begin
				tmp = rq.left; rq.left = rq.right; rq.right = tmp;
			end
		end else if (sel < 8) begin
			// empty: inverted rows or inverted columns
			rq.top = coord_t'($urandom_range(127, 1));
			rq.bottom = coord_t'($urandom_range(rq.top - 1));
			rq.left = coord_t'($urandom_range(127));
			rq.right = coord_t'($urandom_range(127));
			if (sel < 4) begin
				tmp = rq.top; rq.top = rq.left; rq.left = tmp;
				tmp = rq.bottom; rq.bottom = rq.right; rq.right = tmp;
			end
		end else begin
			h = (sel < 20) ? $urandom_range(32, 1) : $urandom_range(8, 1);
			w = (sel < 20) ? $urandom_range(32, 1) : $urandom_range(8, 1);
			rq.top = coord_t'($urandom_range(GRID_ROWS - h));
			rq.left = coord_t'($urandom_range(GRID_COLS - w));
			rq.bottom = rq.top + coord_t'(h - 1);
			rq.right = rq.left + coord_t'(w - 1);
		end
		return rq;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_cells.size() == 0) begin
				$error("cell_value: expected no word, got %0d", cell_value);
				mismatch_count++;
			end else begin
				if (cell_value !== expected_cells[0]) begin
					$error("cell_value: expected %0d, got %0d", expected_cells[0], cell_value);
					mismatch_count++;
				end
				void'(expected_cells.pop_front());
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		int idle_by_phase [4];
		int stall_by_phase [4];
		idle_by_phase = '{0, 80, 0, 18};
		stall_by_phase = '{0, 0, 80, 18};

		// whole grid first: nothing is read before it is written
		add_row(REQ_FILL, 0, 0, 127, 127, 32'sd0, 1'b0, '0);
		add_row(REQ_READ, 0, 0, 0, 0, 32'sd0, 1'b1, 32'sd0);
		add_row(REQ_READ, 127, 127, 0, 0, 32'sd0, 1'b1, 32'sd0);
		add_row(REQ_FILL, 0, 0, 0, 0, 32'sh7FFF_FFFF, 1'b0, '0);
		add_row(REQ_READ, 0, 0, 0, 0, 32'sd0, 1'b1, 32'sh7FFF_FFFF);
		add_row(REQ_FILL, 127, 127, 127, 127, 32'sh8000_0000, 1'b0, '0);
		add_row(REQ_READ, 127, 127, 127, 127, -32'sd1, 1'b1, 32'sh8000_0000);
		add_row(REQ_FILL, 0, 127, 127, 127, -32'sd1, 1'b0, '0);
		add_row(REQ_READ, 0, 127, 0, 0, 32'sd0, 1'b1, -32'sd1);
		add_row(REQ_READ, 127, 127, 0, 0, 32'sd0, 1'b1, -32'sd1);
		add_row(REQ_FILL, 127, 0, 127, 127, 32'sh5555_AAAA, 1'b0, '0);
		add_row(REQ_READ, 127, 0, 0, 0, 32'sd0, 1'b1, 32'sh5555_AAAA);
		add_row(REQ_READ, 127, 127, 0, 0, 32'sd0, 1'b1, 32'sh5555_AAAA);
		// empty rectangles leave the grid alone
		add_row(REQ_FILL, 5, 5, 4, 9, 32'sd123, 1'b0, '0);
		add_row(REQ_READ, 5, 5, 0, 0, 32'sd0, 1'b1, 32'sd0);
		add_row(REQ_FILL, 10, 10, 20, 9, 32'sd456, 1'b0, '0);
		add_row(REQ_READ, 10, 10, 0, 0, 32'sd0, 1'b1, 32'sd0);
		add_row(REQ_FILL, 127, 127, 0, 0, 32'sd789, 1'b0, '0);
		add_row(REQ_READ, 64, 64, 0, 0, 32'sd0, 1'b1, 32'sd0);
		// read ignores the fill-only fields
		add_row(REQ_READ, 1, 2, 127, 127, -32'sd5, 1'b1, 32'sd0);
		add_row(REQ_FILL, 3, 4, 9, 6, 32'sh1234_5678, 1'b0, '0);
		add_row(REQ_FILL, 6, 5, 12, 40, -32'sd77, 1'b0, '0);
		add_row(REQ_READ, 9, 4, 0, 0, 32'sd0, 1'b0, '0);
		add_row(REQ_READ, 9, 6, 0, 0, 32'sd0, 1'b0, '0);
		add_row(REQ_READ, 2, 4, 0, 0, 32'sd0, 1'b0, '0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (request_table[i])
			send_request(request_table[i]);

		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = idle_by_phase[phase];
			recv_stall_pct = stall_by_phase[phase];
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_request(random_request(phase*PHASE_ITEMS + i));
		end
		in_valid <= 1'b0;

		while (expected_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("rect_fill_point_read_grid verification clean");
		else
			$display("rect_fill_point_read_grid verification failed");
		$finish;
	end

endmodule
